/* src/msw_pkg.sv */
// ----------------------------------------------------------------------------
// msw_pkg
// Shared types and constants of the mean-shift pixel weight block.
// ----------------------------------------------------------------------------
package msw_pkg;

	// command codes carried in the input tuser
	typedef enum logic [1:0] {
		CMD_LOAD_MODEL = 2'd0,
		CMD_LOAD_CAND  = 2'd1,
		CMD_PIXEL      = 2'd2
	} cmd_t;

	localparam int CHAN_W      = 8;
	localparam int BIN_IDX_W   = 6;
	localparam int HIST_IN_W   = 10;
	localparam int QUOT_W      = 31;
	localparam int WEIGHT_W    = 22;
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	// control that travels with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic sat;
	} msw_ctl_t;

endpackage

/* src/msw_ram.sv */
// ----------------------------------------------------------------------------
// msw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msw_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/msw_div.sv */
// ----------------------------------------------------------------------------
// msw_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), clipped to
// 2^31-1. One clip-check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module msw_div
	import msw_pkg::*;
#(
	parameter int HIST_BITS = 10,
	parameter int FRAC_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  msw_ctl_t                ctl_in,
	input  logic [3*HIST_BITS-1:0]  num,
	input  logic [3*HIST_BITS-1:0]  den,
	output msw_ctl_t                ctl_out,
	output logic [QUOT_W-1:0]       quot
);

	localparam int DENW = 3 * HIST_BITS;
	localparam int CW   = DENW + QUOT_W;
	localparam int DXW  = DENW + FRAC_BITS + QUOT_W;

	logic [CW-1:0]     num_x;
	logic [CW-1:0]     den_x;
	logic              clip;
	logic [DXW-1:0]    dvd_x;

	msw_ctl_t          ctl_s  [QUOT_W+1];
	logic [DENW-1:0]   rem_s  [QUOT_W+1];
	logic [DENW-1:0]   den_s  [QUOT_W+1];
	logic [QUOT_W-1:0] lo_s   [QUOT_W+1];
	logic [QUOT_W-1:0] quot_s [QUOT_W+1];

	// quotient overflows 31 bits when num >= den * 2^(31-FRAC_BITS)
	assign num_x = CW'(num);
	assign den_x = CW'(den) << (QUOT_W - FRAC_BITS);
	assign clip  = (den == '0) || (num_x >= den_x);
	assign dvd_x = DXW'({num, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid <= ctl_in.valid;
			ctl_s[0].sat   <= clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dvd_x[QUOT_W +: DENW];
			lo_s[0]   <= dvd_x[QUOT_W-1:0];
			den_s[0]  <= den;
			quot_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QUOT_W; k++) begin : g_step
		logic [DENW:0] trial;
		logic          ge;

		assign trial = {rem_s[k], lo_s[k][QUOT_W-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? DENW'(trial - {1'b0, den_s[k]}) : DENW'(trial);
				lo_s[k+1]   <= {lo_s[k][QUOT_W-2:0], 1'b0};
				den_s[k+1]  <= den_s[k];
				quot_s[k+1] <= {quot_s[k][QUOT_W-2:0], ge};
			end
		end
	end

	assign ctl_out = ctl_s[QUOT_W];
	assign quot    = ctl_s[QUOT_W].sat ? {QUOT_W{1'b1}} : quot_s[QUOT_W];

endmodule

/* src/msw_sqrt.sv */
// ----------------------------------------------------------------------------
// msw_sqrt
// Pipelined digit-by-digit square root of quot * 2^FRAC_BITS, truncated.
// One root bit per stage.
// ----------------------------------------------------------------------------
module msw_sqrt
	import msw_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  msw_ctl_t                            ctl_in,
	input  logic [QUOT_W-1:0]                   quot,
	output msw_ctl_t                            ctl_out,
	output logic [(QUOT_W+FRAC_BITS+1)/2-1:0]   root
);

	localparam int SW = (QUOT_W + FRAC_BITS + 1) / 2;
	localparam int AW = 2 * SW;
	localparam int RW = SW + 3;

	msw_ctl_t      ctl_s  [SW+1];
	logic [AW-1:0] rad_s  [SW+1];
	logic [RW-1:0] rem_s  [SW+1];
	logic [SW-1:0] root_s [SW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= AW'({quot, {FRAC_BITS{1'b0}}});
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_step
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_s[k][RW-3:0], rad_s[k][AW-1 -: 2]};
		assign trial = RW'({root_s[k], 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][AW-3:0], 2'b00};
				rem_s[k+1]  <= ge ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][SW-2:0], ge};
			end
		end
	end

	assign ctl_out = ctl_s[SW];
	assign root    = root_s[SW];

endmodule

/* src/mean_shift_pixel_weight.sv */
// ----------------------------------------------------------------------------
// mean_shift_pixel_weight
// Mean-shift tracking weight per pixel from model and candidate histograms.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser holds the command. Load-model and
// load-candidate words write one histogram entry (channel * bins + bin) and
// give no output word; out-of-range loads and the unused command are dropped.
// A pixel word looks up its three channel bins in both tables and gives one
// output word: weight = sqrt(model product / candidate product) in Q12 and a
// saturation flag for a zero denominator or an overflowing quotient.
// Each table is split into three per-channel RAMs, so a pixel reads all six
// entries in its accept cycle; a load is visible to the very next pixel.
// Throughput: one word per cycle while no output word is held, loads and
// pixels mixed freely. From accept to m_axis_tvalid a pixel passes the table
// read, the product registers, the divider clip check, one quotient bit per
// divider stage, one root bit per square-root stage and the output register.
// Reset clears every pipeline valid bit; table contents are kept and must be
// loaded before use. When the receiver stalls, the whole pipeline holds and
// s_axis_tready drops with it; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mean_shift_pixel_weight
	import msw_pkg::*;
#(
	parameter int BINS_PER_CHANNEL = 16,
	parameter int FRAC_BITS        = 12,
	parameter int HIST_BITS        = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// bin_index[5:0], hist_value[15:6], chan_first[23:16],
	// chan_second[31:24], chan_third[39:32]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// weight[21:0], zero pad[23:22]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// saturated[0]
	output logic                   m_axis_tuser
);

	localparam int BW   = $clog2(BINS_PER_CHANNEL);
	localparam int IXW  = $clog2(3 * BINS_PER_CHANNEL + 64);
	localparam int PW   = CHAN_W + $clog2(BINS_PER_CHANNEL + 1);
	localparam int H2   = 2 * HIST_BITS;
	localparam int H3   = 3 * HIST_BITS;
	localparam int SW   = (QUOT_W + FRAC_BITS + 1) / 2;

	logic                 en;
	logic                 accept;
	cmd_t                 cmd;
	logic [BIN_IDX_W-1:0] bin_index;
	logic [HIST_IN_W-1:0] hist_value;
	logic [CHAN_W-1:0]    chan [3];
	logic [BW-1:0]        rd_bin [3];
	logic [IXW-1:0]       idx_x;
	logic [2:0]           ld_hit;
	logic [BW-1:0]        ld_addr;
	logic                 rd_en;
	logic [HIST_BITS-1:0] model_rd [3];
	logic [HIST_BITS-1:0] cand_rd [3];

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic [H2-1:0]        mprod_s2;
	logic [H2-1:0]        cprod_s2;
	logic [HIST_BITS-1:0] mlast_s2;
	logic [HIST_BITS-1:0] clast_s2;
	logic [H3-1:0]        num_s3;
	logic [H3-1:0]        den_s3;

	msw_ctl_t             div_ctl_in;
	msw_ctl_t             div_ctl;
	logic [QUOT_W-1:0]    quot;
	msw_ctl_t             sqrt_ctl;
	logic [SW-1:0]        root;

	logic                 valid_q;
	logic                 sat_q;
	logic [WEIGHT_W-1:0]  weight_q;

	// advance the whole pipeline unless the output word is held
	assign en            = !valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	assign cmd        = cmd_t'(s_axis_tuser);
	assign bin_index  = s_axis_tdata[BIN_IDX_W-1:0];
	assign hist_value = s_axis_tdata[BIN_IDX_W +: HIST_IN_W];
	assign chan[0]    = s_axis_tdata[16 +: CHAN_W];
	assign chan[1]    = s_axis_tdata[24 +: CHAN_W];
	assign chan[2]    = s_axis_tdata[32 +: CHAN_W];
	assign rd_en      = accept && (cmd == CMD_PIXEL);

	for (genvar c = 0; c < 3; c++) begin : g_bin
		logic [PW-1:0] scaled;
		assign scaled    = PW'(chan[c]) * PW'(BINS_PER_CHANNEL);
		assign rd_bin[c] = scaled[CHAN_W +: BW];
	end

	// split the load index into channel and bin
	assign idx_x = IXW'(bin_index);
	always_comb begin
		ld_hit  = '0;
		ld_addr = '0;
		if (idx_x < IXW'(BINS_PER_CHANNEL)) begin
			ld_hit[0] = 1'b1;
			ld_addr   = BW'(idx_x);
		end else if (idx_x < IXW'(2 * BINS_PER_CHANNEL)) begin
			ld_hit[1] = 1'b1;
			ld_addr   = BW'(idx_x - IXW'(BINS_PER_CHANNEL));
		end else if (idx_x < IXW'(3 * BINS_PER_CHANNEL)) begin
			ld_hit[2] = 1'b1;
			ld_addr   = BW'(idx_x - IXW'(2 * BINS_PER_CHANNEL));
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_tab
		msw_ram #(
			.WIDTH (HIST_BITS),
			.DEPTH (BINS_PER_CHANNEL)
		) u_model (
			.clk   (clk),
			.we    (accept && (cmd == CMD_LOAD_MODEL) && ld_hit[c]),
			.waddr (ld_addr),
			.wdata (HIST_BITS'(hist_value)),
			.re    (rd_en),
			.raddr (rd_bin[c]),
			.rdata (model_rd[c])
		);

		msw_ram #(
			.WIDTH (HIST_BITS),
			.DEPTH (BINS_PER_CHANNEL)
		) u_cand (
			.clk   (clk),
			.we    (accept && (cmd == CMD_LOAD_CAND) && ld_hit[c]),
			.waddr (ld_addr),
			.wdata (HIST_BITS'(hist_value)),
			.re    (rd_en),
			.raddr (rd_bin[c]),
			.rdata (cand_rd[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mprod_s2 <= H2'(model_rd[0]) * H2'(model_rd[1]);
			cprod_s2 <= H2'(cand_rd[0]) * H2'(cand_rd[1]);
			mlast_s2 <= model_rd[2];
			clast_s2 <= cand_rd[2];
			num_s3   <= H3'(mprod_s2) * H3'(mlast_s2);
			den_s3   <= H3'(cprod_s2) * H3'(clast_s2);
		end
	end

	assign div_ctl_in.valid = valid_s3;
	assign div_ctl_in.sat   = 1'b0;

	msw_div #(
		.HIST_BITS (HIST_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (div_ctl_in),
		.num     (num_s3),
		.den     (den_s3),
		.ctl_out (div_ctl),
		.quot    (quot)
	);

	msw_sqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (div_ctl),
		.quot    (quot),
		.ctl_out (sqrt_ctl),
		.root    (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= sqrt_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q    <= sqrt_ctl.sat;
			weight_q <= WEIGHT_W'(root);
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(weight_q);
	assign m_axis_tuser  = sat_q;

endmodule

/* src/msw_checker.sv */
// ----------------------------------------------------------------------------
// msw_checker
// Port-level checks of the mean-shift pixel weight block, bound to the top.
// ----------------------------------------------------------------------------
module msw_checker
	import msw_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused with empty output");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:WEIGHT_W] == '0)
		else $error("output pad bits not zero");

endmodule

bind mean_shift_pixel_weight msw_checker u_msw_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench of mean_shift_pixel_weight. Histogram loads and pixel words
// are sent with random gaps while the receiver stalls at random. A predictor
// keeps its own copy of both tables and computes each pixel weight, which is
// compared field by field with the output words in order.
// ----------------------------------------------------------------------------
module tb_top;
	import msw_pkg::*;

	localparam int NBINS     = 16;
	localparam int DEPTH     = 3 * NBINS;
	localparam int FRAC      = 12;
	localparam int IDLE_MAX  = 3000;
	localparam logic [63:0] QMAX = 64'h7FFF_FFFF;

	typedef struct {
		logic [WEIGHT_W-1:0] weight;
		logic                sat;
	} weight_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	logic [9:0] model_hist [DEPTH];
	logic [9:0] cand_hist  [DEPTH];
	weight_t    weight_q[$];
	int         err_cnt;
	int         pixel_cnt;
	int         sat_cnt;
	int         idle_cnt;
	int         stall_left;

	mean_shift_pixel_weight dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// weight of one pixel from the current tables
	function automatic weight_t pixel_weight(input logic [7:0] c0, c1, c2);
		weight_t     w;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		int          b0, b1, b2;
		b0 = c0 >> 4;
		b1 = NBINS + (c1 >> 4);
		b2 = 2 * NBINS + (c2 >> 4);
		num = 64'(model_hist[b0]) * 64'(model_hist[b1]) * 64'(model_hist[b2]);
		den = 64'(cand_hist[b0]) * 64'(cand_hist[b1]) * 64'(cand_hist[b2]);
		w.sat = 1'b0;
		if (den == 0) begin
			q = QMAX;
			w.sat = 1'b1;
		end else begin
			q = (num << FRAC) / den;
			if (q > QMAX) begin
				q = QMAX;
				w.sat = 1'b1;
			end
		end
		w.weight = WEIGHT_W'(isqrt(q << FRAC));
		return w;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_cnt++;
	endtask

	// send one word; returns at the posedge after its gap
	task automatic send_word(input cmd_t cmd_in, input logic [1:0] cmd_raw, input bit use_raw,
	                         input logic [5:0] idx, input logic [9:0] hv,
	                         input logic [7:0] c0, c1, c2);
		bit         acc;
		int         gap;
		logic [1:0] cmd;
		cmd = use_raw ? cmd_raw : cmd_in;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {c2, c1, c0, hv, idx};
		acc = 0;
		while (!acc) begin
			@(negedge clk);
			acc = s_axis_tready;
			@(posedge clk);
		end
		if (cmd == CMD_LOAD_MODEL && idx < DEPTH)
			model_hist[idx] = hv;
		else if (cmd == CMD_LOAD_CAND && idx < DEPTH)
			cand_hist[idx] = hv;
		else if (cmd == CMD_PIXEL) begin
			weight_q.push_back(pixel_weight(c0, c1, c2));
			pixel_cnt++;
		end
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load(input cmd_t cmd, input logic [5:0] idx, input logic [9:0] hv);
		send_word(cmd, 2'b00, 0, idx, hv, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic pixel(input logic [7:0] c0, c1, c2);
		send_word(CMD_PIXEL, 2'b00, 0, 6'($urandom), 10'($urandom), c0, c1, c2);
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (weight_q.size() != 0)
			@(posedge clk);
	endtask

	// set the bins hit by pixel (0,0,0) and pixel (255,255,255)
	task automatic set_corners(input logic [9:0] mv, input logic [9:0] cv);
		for (int c = 0; c < 3; c++) begin
			load(CMD_LOAD_MODEL, 6'(c * NBINS), mv);
			load(CMD_LOAD_MODEL, 6'(c * NBINS + NBINS - 1), mv);
			load(CMD_LOAD_CAND, 6'(c * NBINS), cv);
			load(CMD_LOAD_CAND, 6'(c * NBINS + NBINS - 1), cv);
		end
	endtask

	task automatic test_fill_tables();
		for (int i = 0; i < DEPTH; i++) begin
			load(CMD_LOAD_MODEL, 6'(i), 10'($urandom));
			load(CMD_LOAD_CAND, 6'(i), 10'($urandom_range(1, 1023)));
		end
		pixel(8'd0, 8'd128, 8'd255);
	endtask

	task automatic test_extremes();
		// huge quotient clips, zero denominator saturates, small ratio
		set_corners(10'd1023, 10'd1);
		pixel(8'd0, 8'd0, 8'd0);
		pixel(8'd255, 8'd255, 8'd255);
		set_corners(10'd0, 10'd0);
		pixel(8'd0, 8'd0, 8'd0);
		set_corners(10'd1, 10'd1023);
		pixel(8'd255, 8'd255, 8'd255);
		set_corners(10'd1023, 10'd1023);
		pixel(8'd15, 8'd240, 8'd255);
		drain();
	endtask

	task automatic test_ignored();
		// out-of-range loads and the unused command must leave tables alone
		for (int i = DEPTH; i < 64; i += 5) begin
			load(CMD_LOAD_MODEL, 6'(i), 10'($urandom));
			load(CMD_LOAD_CAND, 6'(i), 10'($urandom));
		end
		load(CMD_LOAD_MODEL, 6'd63, 10'd0);
		for (int i = 0; i < 4; i++)
			send_word(CMD_PIXEL, 2'b11, 1, 6'($urandom), 10'($urandom),
			          8'($urandom), 8'($urandom), 8'($urandom));
		pixel(8'd0, 8'd0, 8'd0);
		pixel(8'd255, 8'd255, 8'd255);
		drain();
	endtask

	task automatic test_random(input int n);
		int          r;
		logic [9:0]  hv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				hv = 10'd0;
			else if (r < 30)
				hv = 10'($urandom_range(1, 15));
			else
				hv = 10'($urandom);
			r = $urandom_range(0, 99);
			if (r < 20)
				load(CMD_LOAD_MODEL, 6'($urandom_range(0, DEPTH - 1)), hv);
			else if (r < 40)
				load(CMD_LOAD_CAND, 6'($urandom_range(0, DEPTH - 1)), hv);
			else if (r < 43)
				load(r[0] ? CMD_LOAD_CAND : CMD_LOAD_MODEL,
				     6'($urandom_range(DEPTH, 63)), hv);
			else if (r < 45)
				send_word(CMD_PIXEL, 2'b11, 1, 6'($urandom), hv,
				          8'($urandom), 8'($urandom), 8'($urandom));
			else
				pixel(8'($urandom), 8'($urandom), 8'($urandom));
			if (i == n / 2)
				drain();
		end
	endtask

	// receiver: random stalls, mostly short
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= gap_len();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// check the word that the next edge accepts; inputs are stable here
	always @(negedge clk) begin
		weight_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (weight_q.size() == 0) begin
				report("output word with nothing expected");
			end else begin
				w = weight_q.pop_front();
				if (m_axis_tdata[WEIGHT_W-1:0] !== w.weight)
					report($sformatf("weight %0d, want %0d",
					       m_axis_tdata[WEIGHT_W-1:0], w.weight));
				if (m_axis_tuser !== w.sat)
					report($sformatf("saturated %0b, want %0b", m_axis_tuser, w.sat));
				if (w.sat)
					sat_cnt++;
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= IDLE_MAX) begin
			$display("[mean_shift_pixel_weight] ERROR");
			$finish;
		end
	end

	initial begin
		err_cnt = 0;
		pixel_cnt = 0;
		sat_cnt = 0;
		idle_cnt = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_tables();
		test_extremes();
		test_ignored();
		test_random(1150);
		drain();
		repeat (100) @(posedge clk);
		if (weight_q.size() != 0)
			report($sformatf("%0d expected words never came", weight_q.size()));
		$display("covered %0d pixel words (%0d saturated) among loads, dropped loads",
		         pixel_cnt, sat_cnt);
		$display("and unused commands, with random gaps and output stalls");
		if (err_cnt == 0)
			$display("[mean_shift_pixel_weight] OK");
		else
			$display("[mean_shift_pixel_weight] ERROR");
		$finish;
	end

endmodule

/* mean_shift_pixel_weight.f */
src/msw_pkg.sv
src/msw_ram.sv
src/msw_div.sv
src/msw_sqrt.sv
src/mean_shift_pixel_weight.sv
src/msw_checker.sv
verif/tb_top.sv
